### rtl/bqf_pkg.sv
package bqf_pkg;

    // Sample and coefficient word width.
    localparam int C_DATA_W = 32;

    // Width of the full product sum.
    localparam int C_ACC_W = 2 * C_DATA_W;

    // Fractional bits of the coefficients.
    localparam int C_FRAC_BITS = 25;

    // Register index width and register indexes.
    localparam int C_CFG_IDX_W = 3;

    localparam logic [C_CFG_IDX_W-1:0] C_REG_B0     = C_CFG_IDX_W'(0);
    localparam logic [C_CFG_IDX_W-1:0] C_REG_B1     = C_CFG_IDX_W'(1);
    localparam logic [C_CFG_IDX_W-1:0] C_REG_B2     = C_CFG_IDX_W'(2);
    localparam logic [C_CFG_IDX_W-1:0] C_REG_NEG_A1 = C_CFG_IDX_W'(3);
    localparam logic [C_CFG_IDX_W-1:0] C_REG_NEG_A2 = C_CFG_IDX_W'(4);

    // Unity gain in coefficient format, the reset value of b0.
    localparam logic signed [C_DATA_W-1:0] C_COEF_ONE =
        C_DATA_W'(64'd1 << C_FRAC_BITS);

    // Half an output step, added before the shift so that it rounds.
    localparam logic [C_ACC_W-1:0] C_ROUND = C_ACC_W'(64'd1 << (C_FRAC_BITS - 1));

    typedef logic signed [C_DATA_W-1:0] t_sample;

    typedef struct packed {
        t_sample b0;
        t_sample b1;
        t_sample b2;
        t_sample neg_a1;
        t_sample neg_a2;
    } t_coefs;

endpackage

### rtl/bqf_in_if.sv
interface bqf_in_if
    import bqf_pkg::*;
();
    logic    valid;
    logic    ready;
    t_sample sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

### rtl/bqf_out_if.sv
interface bqf_out_if
    import bqf_pkg::*;
();
    logic    valid;
    logic    ready;
    t_sample sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

### rtl/bqf_cfg_if.sv
interface bqf_cfg_if
    import bqf_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [C_CFG_IDX_W-1:0] index;
    logic [C_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/bqf_coef_regs.sv
module bqf_coef_regs
    import bqf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    bqf_cfg_if.sink i_cfg,
    output t_coefs o_coefs
);

    t_coefs r_coefs;
    t_coefs n_coefs;

    assign i_cfg.ready = 1'b1;

    // Writes to indexes past the last register are dropped.
    always_comb begin
        n_coefs = r_coefs;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                C_REG_B0:     n_coefs.b0     = t_sample'(i_cfg.data);
                C_REG_B1:     n_coefs.b1     = t_sample'(i_cfg.data);
                C_REG_B2:     n_coefs.b2     = t_sample'(i_cfg.data);
                C_REG_NEG_A1: n_coefs.neg_a1 = t_sample'(i_cfg.data);
                C_REG_NEG_A2: n_coefs.neg_a2 = t_sample'(i_cfg.data);
                default:      n_coefs        = r_coefs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0     <= C_COEF_ONE;
            r_coefs.b1     <= '0;
            r_coefs.b2     <= '0;
            r_coefs.neg_a1 <= '0;
            r_coefs.neg_a2 <= '0;
        end else begin
            r_coefs <= n_coefs;
        end
    end

    assign o_coefs = r_coefs;

endmodule

### rtl/bqf_datapath.sv
module bqf_datapath
    import bqf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_coefs  i_coefs,
    input  t_sample i_x,
    input  logic    i_adv,
    output t_sample o_y
);

    t_sample r_x_prev1;
    t_sample r_x_prev2;
    t_sample r_y_prev1;
    t_sample r_y_prev2;

    logic signed [C_ACC_W-1:0] w_p0;
    logic signed [C_ACC_W-1:0] w_p1;
    logic signed [C_ACC_W-1:0] w_p2;
    logic signed [C_ACC_W-1:0] w_p3;
    logic signed [C_ACC_W-1:0] w_p4;
    logic        [C_ACC_W-1:0] w_acc;
    t_sample                   w_y;

    // Five signed products, each sign-extended to the full sum width.
    assign w_p0 = C_ACC_W'(i_coefs.b0)     * C_ACC_W'(i_x);
    assign w_p1 = C_ACC_W'(i_coefs.b1)     * C_ACC_W'(r_x_prev1);
    assign w_p2 = C_ACC_W'(i_coefs.b2)     * C_ACC_W'(r_x_prev2);
    assign w_p3 = C_ACC_W'(i_coefs.neg_a1) * C_ACC_W'(r_y_prev1);
    assign w_p4 = C_ACC_W'(i_coefs.neg_a2) * C_ACC_W'(r_y_prev2);

    // The sum wraps; the low word of the shifted sum is the same for an
    // arithmetic and a logical shift, so a part-select does it.
    assign w_acc = C_ACC_W'(w_p0) + C_ACC_W'(w_p1) + C_ACC_W'(w_p2)
                 + C_ACC_W'(w_p3) + C_ACC_W'(w_p4) + C_ROUND;
    assign w_y   = t_sample'(w_acc[C_FRAC_BITS +: C_DATA_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_prev1 <= '0;
            r_x_prev2 <= '0;
            r_y_prev1 <= '0;
            r_y_prev2 <= '0;
        end else if (i_adv) begin
            r_x_prev2 <= r_x_prev1;
            r_x_prev1 <= i_x;
            r_y_prev2 <= r_y_prev1;
            r_y_prev1 <= w_y;
        end
    end

    assign o_y = w_y;

endmodule

### rtl/fixed_point_biquad_filter_unit.sv
// Direct-form-I biquad on signed 32-bit samples with five signed Q25
// coefficients (b0, b1, b2 and the already negated feedback terms a1, a2),
// written through the configuration channel at indexes 0 to 4; writes at
// higher indexes are ignored. Each output is the rounded, wrapping (not
// saturating) low word of the five-product sum shifted right by 25. After
// reset the history is zero and the filter passes samples straight through.
// The block takes one sample beat per clock while the output is not
// stalled. A sample held in the input register has its result loaded into
// the output register when the output register is free; the five
// multipliers and the adder tree sit combinationally between the two
// registers. The recursion through the previous output must close within
// that combinational path, and that is what allows the rate of one sample
// per clock; a stalled output holds the input back once both registers are
// full.

module fixed_point_biquad_filter_unit
    import bqf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    bqf_cfg_if.sink    i_cfg,
    bqf_in_if.sink     i_in,
    bqf_out_if.source  o_out
);

    t_coefs  w_coefs;
    t_sample w_y;

    // Input register stage.
    logic    r_x_valid;
    t_sample r_x;

    // Output register stage.
    logic    r_y_valid;
    t_sample r_y;

    logic w_out_free;
    logic w_adv;
    logic w_in_accept;

    // The output register can take a new result when it is empty or its
    // current beat is being taken this cycle.
    assign w_out_free  = !r_y_valid || o_out.ready;

    // A sample in the input register moves on, and the filter history
    // shifts, only when its result has somewhere to go.
    assign w_adv       = r_x_valid && w_out_free;

    // The input register is free when empty or emptying, so a new sample
    // is taken every cycle while the output keeps flowing, and one more is
    // still taken while a finished result waits downstream.
    assign i_in.ready  = !r_x_valid || w_adv;
    assign w_in_accept = i_in.valid && i_in.ready;

    bqf_coef_regs u_coef_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_coefs (w_coefs)
    );

    bqf_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coefs (w_coefs),
        .i_x     (r_x),
        .i_adv   (w_adv),
        .o_y     (w_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid <= 1'b0;
            r_y_valid <= 1'b0;
        end else begin
            r_x_valid <= w_in_accept || (r_x_valid && !w_adv);
            r_y_valid <= w_adv || (r_y_valid && !o_out.ready);
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_x <= i_in.sample_in;
        end
        if (w_adv) begin
            r_y <= w_y;
        end
    end

    assign o_out.valid      = r_y_valid;
    assign o_out.sample_out = r_y;

endmodule
